FILE: sv/pol_pkg.sv
package pol_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_INSERT = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_RANGE    = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    // Field widths of the stream words
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int OUTN_W  = 7;

    // Operation broadcast along the cell row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MATCH
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [VALUE_W-1:0]   key;
    } t_cell_bus;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TREE,
        ST_DONE
    } t_state;

endpackage

FILE: sv/pol_cell.sv
module pol_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  logic                          i_clk,
    input  pol_pkg::t_cell_bus            i_bus,
    input  logic [IDX_W-1:0]              i_pos,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [pol_pkg::VALUE_W-1:0]   i_left,
    input  logic [pol_pkg::VALUE_W-1:0]   i_right,
    output logic [pol_pkg::VALUE_W-1:0]   o_entry,
    output logic                          o_match
);
    import pol_pkg::*;

    logic [VALUE_W-1:0] r_entry;
    logic               r_match;

    // Entry: open a gap at the insert point, or close up from the right on delete
    always_ff @(posedge i_clk) begin
        case (i_bus.op)
            CELL_INSERT: begin
                if (i_pos == IDX_W'(CELL_IDX)) begin
                    r_entry <= i_bus.key;
                end else if (i_pos < IDX_W'(CELL_IDX)) begin
                    r_entry <= i_left;
                end
            end
            CELL_DELETE: begin
                if (i_pos <= IDX_W'(CELL_IDX)) begin
                    r_entry <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    // Match flag, only for entries inside the list; held until the next search
    always_ff @(posedge i_clk) begin
        if (i_bus.op == CELL_MATCH) begin
            r_match <= (r_entry == i_bus.key) && (CNT_W'(CELL_IDX) < i_count);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

FILE: sv/pol_prio_tree.sv
module pol_prio_tree #(
    parameter int LEAF_N = 64,
    parameter int IDX_W  = 6
) (
    input  logic              i_clk,
    input  logic [LEAF_N-1:0] i_hit,
    output logic              o_hit,
    output logic [IDX_W-1:0]  o_idx
);
    import pol_pkg::*;

    localparam int LEAVES = 1 << IDX_W;
    localparam int HALF   = LEAVES / 2;

    logic [LEAVES-1:0] w_leaf;
    // heap order: node 1 is the root, children of n are 2n and 2n+1
    logic              r_hit [1:LEAVES-1];
    logic [IDX_W-1:0]  r_idx [1:LEAVES-1];

    // pad the leaf row to a power of two
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < LEAF_N) begin : g_real
            assign w_leaf[i] = i_hit[i];
        end else begin : g_pad
            assign w_leaf[i] = 1'b0;
        end
    end

    // one registered level per tree depth, lowest index wins
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        if (n >= HALF) begin : g_bottom
            localparam int LI = 2 * n - LEAVES;
            always_ff @(posedge i_clk) begin
                r_hit[n] <= w_leaf[LI] | w_leaf[LI+1];
                r_idx[n] <= w_leaf[LI] ? IDX_W'(LI) : IDX_W'(LI + 1);
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_hit[n] <= r_hit[2*n] | r_hit[2*n+1];
                r_idx[n] <= r_hit[2*n] ? r_idx[2*n] : r_idx[2*n+1];
            end
        end
    end

    assign o_hit = r_hit[1];
    assign o_idx = r_idx[1];

endmodule

FILE: sv/positional_ordered_list_core.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// positions counted from 1. Each command word (tuser: clear, search, delete,
// insert) gives one result word with status, first matching position and the
// entry count after the command. Clear, delete, insert and a search of an empty
// list go from the execute state straight to the done state: every cell shifts
// or loads at once. A search of a non-empty list then waits in the tree state,
// for a time set by the depth of the registered first-match tree over the cells'
// compare flags. A result waits in the output register while the next command
// is taken in; the result after it holds the sequencer until the output
// register is read.
module positional_ordered_list_core #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] position, [39:8] value
    input  logic [39:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [9:3] found_position, [16:10] entry_count, [23:17] zero
    output logic [23:0] m_axis_tdata
);
    import pol_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WAIT_W = $clog2(IDX_W + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int FND_W  = ((IDX_W + 1) > OUTN_W) ? (IDX_W + 1) : OUTN_W;
    localparam int OCN_W  = (CNT_W > OUTN_W) ? CNT_W : OUTN_W;

    t_state               r_state, n_state;
    logic [1:0]           r_cmd;
    logic [POS_W-1:0]     r_pos;
    logic [VALUE_W-1:0]   r_key;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [WAIT_W-1:0]    r_wait, n_wait;
    logic [2:0]           r_status, n_status;
    logic                 r_srch, n_srch;

    logic                 r_m_valid;
    logic [2:0]           r_m_status;
    logic [OUTN_W-1:0]    r_m_found;
    logic [OUTN_W-1:0]    r_m_count;

    t_cell_bus            w_bus;
    t_cell_op             w_op;
    logic                 w_load;
    logic [2:0]           w_res_status;
    logic [FND_W-1:0]     w_res_found;
    logic [OCN_W-1:0]     w_cnt_out;
    logic                 w_out_free;
    logic                 w_accept;

    logic [CMP_W-1:0]     w_pos_x;
    logic [CMP_W-1:0]     w_cnt_x;
    logic [CMP_W-1:0]     w_pos_m1;
    logic                 w_bad_del;
    logic                 w_bad_ins;
    logic                 w_full;

    logic [VALUE_W-1:0]   w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_match;
    logic                 w_tree_hit;
    logic [IDX_W-1:0]     w_tree_idx;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // position checks against the current count
    assign w_pos_x   = CMP_W'(r_pos);
    assign w_cnt_x   = CMP_W'(r_count);
    assign w_pos_m1  = w_pos_x - CMP_W'(1);
    assign w_bad_del = (r_pos == '0) || (w_pos_x > w_cnt_x);
    assign w_bad_ins = (r_pos == '0) || (w_pos_x > (w_cnt_x + CMP_W'(1)));
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    // cell row
    assign w_bus.op  = w_op;
    assign w_bus.key = r_key;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = r_key;
        end else begin : g_mid_l
            assign w_left = w_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = r_key;
        end else begin : g_mid_r
            assign w_right = w_entry[i+1];
        end
        pol_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_bus   (w_bus),
            .i_pos   (w_pos_m1[IDX_W-1:0]),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[i]),
            .o_match (w_match[i])
        );
    end

    // first-match search over the compare flags
    pol_prio_tree #(
        .LEAF_N (CAPACITY),
        .IDX_W  (IDX_W)
    ) u_tree (
        .i_clk (i_clk),
        .i_hit (w_match),
        .o_hit (w_tree_hit),
        .o_idx (w_tree_idx)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_wait  <= '0;
            r_srch  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wait  <= n_wait;
            r_srch  <= n_srch;
        end
    end

    // command word capture and pending status
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= s_axis_tuser;
            r_pos <= s_axis_tdata[POS_W-1:0];
            r_key <= s_axis_tdata[POS_W +: VALUE_W];
        end
        r_status <= n_status;
    end

    // next state, cell operation and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_wait       = r_wait;
        n_status     = r_status;
        n_srch       = r_srch;
        w_op         = CELL_HOLD;
        w_load       = 1'b0;
        w_res_status = r_status;
        w_res_found  = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_srch   = 1'b0;
                n_status = STAT_OK;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    CMD_SEARCH: begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            w_op   = CELL_MATCH;
                            n_srch = 1'b1;
                            n_wait = WAIT_W'(IDX_W);
                        end
                    end
                    CMD_DELETE: begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else if (w_bad_del) begin
                            n_status = STAT_RANGE;
                        end else begin
                            w_op    = CELL_DELETE;
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        if (w_bad_ins) begin
                            n_status = STAT_RANGE;
                        end else if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_op    = CELL_INSERT;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                endcase
                n_state = n_srch ? ST_TREE : ST_DONE;
            end
            ST_TREE: begin
                if (r_wait == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_wait = r_wait - WAIT_W'(1);
                end
            end
            ST_DONE: begin
                if (r_srch) begin
                    w_res_status = w_tree_hit ? STAT_OK : STAT_NOTFOUND;
                    w_res_found  = w_tree_hit ? (FND_W'(w_tree_idx) + FND_W'(1)) : '0;
                end
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_srch  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_cnt_out = OCN_W'(r_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_status <= w_res_status;
            r_m_found  <= w_res_found[OUTN_W-1:0];
            r_m_count  <= w_cnt_out[OUTN_W-1:0];
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_m_count, r_m_found, r_m_status};

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !r_srch && (r_status == STAT_FULL) |->
        (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_m_found != '0) |-> (r_m_status == STAT_OK))
        else $error("found position with non-ok status");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted word not executed");

    a_tree_srch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TREE) |-> r_srch)
        else $error("tree wait without a search");
`endif

endmodule
